FILE: rtl/tkis_pkg.sv
// Shared types and constants for the top-K intensity insertion sorter.
// Depends on nothing; used by tkis_list.sv and top_k_intensity_insertion_sorter.sv.
package tkis_pkg;

	localparam int ID_W     = 16;
	localparam int INTEN_W  = 16;
	localparam int RANK_W   = 3;
	localparam int COUNT_W  = 4;
	localparam int APB_DW   = 32;
	localparam int PADDR_W  = 3;

	// Reset value of the threshold register, about 0.01 in Q4.12.
	localparam logic [INTEN_W-1:0] MIN_INTENSITY_RESET = 16'd41;

	// Register index as decoded from paddr[2] (registers lie at 4*i).
	localparam logic REG_MIN_INTENSITY = 1'b0;

	typedef enum logic [1:0] {
		FUNC_CLEAR   = 2'd0,
		FUNC_OFFER   = 2'd1,
		FUNC_PUBLISH = 2'd2
	} func_t;

	// Command word handed from the top level to the candidate list.
	typedef struct packed {
		logic               clear;
		logic               offer;
		logic [ID_W-1:0]    light_id;
		logic [INTEN_W-1:0] intensity;
	} list_cmd_t;

endpackage

FILE: rtl/tkis_list.sv
// Sorted candidate list: a row of slots with parallel compare and shift insert.
// Depends on tkis_pkg.
module tkis_list #(
	parameter int CAPACITY = 8,
	parameter int IDX_W    = 3,
	parameter int CNT_W    = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tkis_pkg::list_cmd_t           cmd,
	input  logic [tkis_pkg::INTEN_W-1:0]  min_intensity,
	input  logic [IDX_W-1:0]              rd_idx,
	output logic [tkis_pkg::ID_W-1:0]     rd_id,
	output logic [tkis_pkg::INTEN_W-1:0]  rd_intensity,
	output logic [CNT_W-1:0]              count
);

	logic [tkis_pkg::ID_W-1:0]    slot_id_q    [CAPACITY];
	logic [tkis_pkg::INTEN_W-1:0] slot_inten_q [CAPACITY];
	logic [CNT_W-1:0]             count_q;
	logic [CAPACITY-1:0]          ge;
	logic                         full;
	logic                         insert;

	assign full = (count_q == CNT_W'(CAPACITY));

	// The offer goes in unless it is under threshold, or the list is full
	// and its weakest entry already matches or beats it.
	assign insert = cmd.offer && (cmd.intensity >= min_intensity) &&
		!(full && (slot_inten_q[CAPACITY-1] >= cmd.intensity));

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		// Held entries at least as intense as the offer form a prefix.
		assign ge[i] = (CNT_W'(i) < count_q) && (slot_inten_q[i] >= cmd.intensity);

		if (i == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (insert && !ge[0]) begin
					slot_id_q[0]    <= cmd.light_id;
					slot_inten_q[0] <= cmd.intensity;
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (insert) begin
					if (!ge[i-1]) begin
						slot_id_q[i]    <= slot_id_q[i-1];
						slot_inten_q[i] <= slot_inten_q[i-1];
					end else if (!ge[i]) begin
						slot_id_q[i]    <= cmd.light_id;
						slot_inten_q[i] <= cmd.intensity;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (insert && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign rd_id        = slot_id_q[rd_idx];
	assign rd_intensity = slot_inten_q[rd_idx];
	assign count        = count_q;

endmodule

FILE: rtl/top_k_intensity_insertion_sorter.sv
// Top level of the top-K intensity insertion sorter: command port, APB register,
// publish sequencer and result register. Depends on tkis_pkg and tkis_list.
//
// Usage. A command word (func, light_id, intensity) is taken at a rising edge
// where start is high and busy is low. It lands in an input register and is
// carried out on the next edge by the candidate list, which keeps up to
// CAPACITY lights sorted by descending intensity. Clear and offer words give
// no results and do not raise busy, so a stream of offers may be fed back to
// back at one word per cycle while busy stays low; each offer sees every
// earlier one. A publish word emits one result per held entry on consecutive
// cycles, rank 0 first, with last set on the final one. An empty list gives a
// single result with entry_valid low and last high. A result is shown for
// exactly one cycle, marked by result_valid; the receiver cannot stall it.
// The first result of a publish passes the input register, the publish
// sequencer and the result register; for an empty list it skips the sequencer.
// Busy is high from the cycle after the word is taken until the last result
// shows. Reset empties the list and loads min_intensity with 41 (about 0.01
// in Q4.12). The user is to write the threshold over the APB port at byte
// address 0 only while the block is idle; the block does not enforce this.
module top_k_intensity_insertion_sorter #(
	parameter int CAPACITY = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Command channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           func,
	input  logic [tkis_pkg::ID_W-1:0]            light_id,
	input  logic [tkis_pkg::INTEN_W-1:0]         intensity,
	// Result channel
	output logic                                 result_valid,
	output logic                                 entry_valid,
	output logic [tkis_pkg::ID_W-1:0]            out_id,
	output logic [tkis_pkg::INTEN_W-1:0]         out_intensity,
	output logic [tkis_pkg::RANK_W-1:0]          rank,
	output logic [tkis_pkg::COUNT_W-1:0]         entry_count,
	output logic                                 last,
	// Configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tkis_pkg::PADDR_W-1:0]         paddr,
	input  logic [tkis_pkg::APB_DW-1:0]          pwdata,
	output logic [tkis_pkg::APB_DW-1:0]          prdata,
	output logic                                 pready
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	// Threshold register.
	logic [tkis_pkg::INTEN_W-1:0] min_intensity_q;
	logic                         cfg_write;

	// Input register stage.
	logic                         valid_s1;
	tkis_pkg::func_t              func_s1;
	logic [tkis_pkg::ID_W-1:0]    id_s1;
	logic [tkis_pkg::INTEN_W-1:0] inten_s1;

	// Publish sequencer.
	logic                         pub_active_q;
	logic [IDX_W-1:0]             pub_idx_q;
	logic                         pub_start;
	logic                         pub_final;

	// List interface.
	tkis_pkg::list_cmd_t          cmd;
	logic [tkis_pkg::ID_W-1:0]    rd_id;
	logic [tkis_pkg::INTEN_W-1:0] rd_intensity;
	logic [CNT_W-1:0]             count;

	logic                         accept;

	// The port always completes in its access cycle. Only paddr[2] selects a
	// register; the single register sits at index zero.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_intensity_q <= tkis_pkg::MIN_INTENSITY_RESET;
		end else if (cfg_write && (paddr[2] == tkis_pkg::REG_MIN_INTENSITY)) begin
			min_intensity_q <= pwdata[tkis_pkg::INTEN_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == tkis_pkg::REG_MIN_INTENSITY) begin
			prdata = {{(tkis_pkg::APB_DW - tkis_pkg::INTEN_W){1'b0}}, min_intensity_q};
		end
	end

	// A publish word holds the port from the moment it reaches the input
	// register until its last result has been loaded.
	assign pub_start = valid_s1 && (func_s1 == tkis_pkg::FUNC_PUBLISH);
	assign busy      = pub_start || pub_active_q;
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= tkis_pkg::func_t'(func);
			id_s1    <= light_id;
			inten_s1 <= intensity;
		end
	end

	// Unused func code 3 decodes to neither clear nor offer and is dropped.
	always_comb begin
		cmd.clear     = 1'b0;
		cmd.offer     = 1'b0;
		cmd.light_id  = id_s1;
		cmd.intensity = inten_s1;
		if (valid_s1) begin
			case (func_s1)
				tkis_pkg::FUNC_CLEAR: cmd.clear = 1'b1;
				tkis_pkg::FUNC_OFFER: cmd.offer = 1'b1;
				default: ;
			endcase
		end
	end

	tkis_list #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_list (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.min_intensity (min_intensity_q),
		.rd_idx        (pub_idx_q),
		.rd_id         (rd_id),
		.rd_intensity  (rd_intensity),
		.count         (count)
	);

	assign pub_final = (CNT_W'(pub_idx_q) + CNT_W'(1)) == count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pub_active_q <= 1'b0;
			pub_idx_q    <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (pub_active_q) begin
				result_valid <= 1'b1;
				if (pub_final) begin
					pub_active_q <= 1'b0;
				end else begin
					pub_idx_q <= pub_idx_q + IDX_W'(1);
				end
			end else if (pub_start) begin
				pub_idx_q <= '0;
				if (count == '0) begin
					// Empty list: a single marker result.
					result_valid <= 1'b1;
				end else begin
					pub_active_q <= 1'b1;
				end
			end
		end
	end

	// Result payload; rank and count are cut to their port widths.
	always_ff @(posedge clk) begin
		if (pub_active_q) begin
			entry_valid   <= 1'b1;
			out_id        <= rd_id;
			out_intensity <= rd_intensity;
			rank          <= tkis_pkg::RANK_W'(pub_idx_q);
			entry_count   <= tkis_pkg::COUNT_W'(count);
			last          <= pub_final;
		end else if (pub_start) begin
			entry_valid   <= 1'b0;
			out_id        <= '0;
			out_intensity <= '0;
			rank          <= '0;
			entry_count   <= '0;
			last          <= 1'b1;
		end
	end

endmodule
